// ----- rtl/core/mwwa_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers for the masked window weighted average.
// No dependencies.
package mwwa_pkg;

	localparam int MAX_HALF_WIDTH = 8;
	localparam int SERIES_DEPTH   = 1024;
	localparam int WEIGHT_DEPTH   = 2 * MAX_HALF_WIDTH + 1;

	localparam logic [1:0] OP_STORE_SAMPLE = 2'd0;
	localparam logic [1:0] OP_STORE_WEIGHT = 2'd1;
	localparam logic [1:0] OP_QUERY        = 2'd2;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_FEW        = 3'd1;
	localparam logic [2:0] ST_UNBALANCED = 3'd2;
	localparam logic [2:0] ST_BAD_CFG    = 3'd3;
	localparam logic [2:0] ST_ZERO_WSUM  = 3'd4;

	localparam logic [1:0] REG_HALF_WIDTH = 2'd0;
	localparam logic [1:0] REG_MIN_PRES   = 2'd1;
	localparam logic [1:0] REG_SERIES_LEN = 2'd2;
	localparam logic [1:0] REG_BALANCE    = 2'd3;

	typedef struct packed {
		logic [1:0]         operation;
		logic [9:0]         index;
		logic signed [31:0] value;
		logic               present;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] window_value;
		logic [2:0]         status;
	} out_word_t;

	// saturate sign/magnitude to signed 32 bits
	function automatic logic [31:0] sat32(input logic neg, input logic [53:0] mag);
		logic [31:0] r;
		if (neg) begin
			if (mag >= 54'h80000000) r = 32'h80000000;
			else r = 32'(-mag[31:0]);
		end else begin
			if (mag > 54'h7FFFFFFF) r = 32'h7FFFFFFF;
			else r = mag[31:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/mwwa_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module mwwa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/masked_window_weighted_average.sv -----
`timescale 1ns / 1ps
// Masked window weighted average, top level. Uses mwwa_pkg and mwwa_ram.
// Holds the series and weight RAMs, the window walk, and the divider.
//
// Store words (sample or weight) are written into RAM in the cycle they are
// accepted. A query walks the 2*half_width+1 window positions through the
// sample and weight RAMs, one position a cycle, with a read stage and a
// multiply stage ahead of the 52-bit accumulator. A full window finishes with
// a round and saturate; a window with missing samples runs a 54-step
// restoring divider, one quotient bit a cycle. Input is stalled while a query
// is in flight; the result sits in an output register so the next word can be
// taken while it waits.
// Registers on the APB port: half_width at 0x0, min_present at 0x4,
// series_length at 0x8, balance_required at 0xC.
module masked_window_weighted_average (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  mwwa_pkg::in_word_t  in_word,
	output logic               out_valid,
	input  logic               out_stall,
	output mwwa_pkg::out_word_t out_word,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import mwwa_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_WALK, S_DECIDE, S_DIV, S_RESULT} state_t;

	// configuration
	logic [3:0]  hw_q;
	logic [4:0]  mp_q;
	logic [10:0] sl_q;
	logic        bal_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q  <= 4'd1;
			mp_q  <= 5'd1;
			sl_q  <= 11'd1;
			bal_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_HALF_WIDTH: hw_q  <= pwdata[3:0];
				REG_MIN_PRES:   mp_q  <= pwdata[4:0];
				REG_SERIES_LEN: sl_q  <= pwdata[10:0];
				REG_BALANCE:    bal_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_HALF_WIDTH: prdata = {28'd0, hw_q};
			REG_MIN_PRES:   prdata = {27'd0, mp_q};
			REG_SERIES_LEN: prdata = {21'd0, sl_q};
			REG_BALANCE:    prdata = {31'd0, bal_q};
			default:        prdata = 32'd0;
		endcase
	end

	// control
	state_t      state_q;
	logic [9:0]  center_q;
	logic [4:0]  j_q;
	logic        iss_q;
	logic        vld_s1, vld_s2;
	logic        inr_s1;
	logic [4:0]  j_s1, j_s2;
	logic        use_s2;
	logic signed [47:0] prod_s2;
	logic signed [15:0] w_s2;
	logic signed [51:0] acc_q;
	logic signed [20:0] wsum_q;
	logic [4:0]  cnt_q;
	logic        before_q, after_q, miss_q;
	logic [53:0] num_q;
	logic [21:0] den_q, rem_q;
	logic [5:0]  div_cnt_q;
	logic        neg_q;
	out_word_t   res_q;

	logic        accept;
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	// final result moves into the output register
	logic        res_load;
	assign res_load = (state_q == S_RESULT) && !(miss_q && res_q.status == ST_OK) &&
		(!out_valid || !out_stall);

	// RAMs: sample word with present flag in the top bit
	logic        s_we, w_we;
	logic [32:0] s_rdata;
	logic [15:0] w_rdata;
	logic [9:0]  s_raddr;

	assign s_we = accept && (in_word.operation == OP_STORE_SAMPLE);
	assign w_we = accept && (in_word.operation == OP_STORE_WEIGHT)
		&& (in_word.index < 10'(WEIGHT_DEPTH));

	// window position of the entry being issued
	logic signed [11:0] k;
	logic        k_in;
	logic [4:0]  nw_m1;
	assign k = $signed({2'b00, center_q}) - $signed({8'd0, hw_q}) + $signed({7'd0, j_q});
	assign k_in = (k >= 12'sd0) && (k < $signed({1'b0, sl_q}));
	assign s_raddr = k[9:0];
	assign nw_m1 = {hw_q, 1'b0};

	mwwa_ram #(.WIDTH(33), .DEPTH(SERIES_DEPTH)) u_samples (
		.clk(clk), .we(s_we), .waddr(in_word.index),
		.wdata({in_word.present, in_word.value}),
		.raddr(s_raddr), .rdata(s_rdata)
	);

	mwwa_ram #(.WIDTH(16), .DEPTH(WEIGHT_DEPTH)) u_weights (
		.clk(clk), .we(w_we), .waddr(in_word.index[4:0]),
		.wdata(in_word.value[15:0]),
		.raddr(j_q), .rdata(w_rdata)
	);

	// settings check and decision terms
	logic        bad_cfg;
	logic [5:0]  nw;
	assign nw = {1'b0, hw_q, 1'b1};
	assign bad_cfg = (hw_q < 4'd1) || (hw_q > 4'(MAX_HALF_WIDTH)) ||
		(sl_q < 11'd1) || (sl_q > 11'(SERIES_DEPTH)) ||
		(mp_q < 5'd1) || ({1'b0, mp_q} > nw) || ({6'd0, mp_q} > sl_q);

	logic [51:0] na;
	logic [20:0] nd;
	logic [37:0] full_mag;
	assign na = acc_q[51] ? 52'(-acc_q) : 52'(acc_q);
	assign nd = wsum_q[20] ? 21'(-wsum_q) : 21'(wsum_q);
	assign full_mag = 38'((53'(na) + 53'h4000) >> 15);

	// divider step
	logic [22:0] rem_sh;
	logic        ge;
	assign rem_sh = {rem_q, num_q[53]};
	assign ge = (rem_sh >= {1'b0, den_q});

	logic use_s1;
	assign use_s1 = vld_s1 && inr_s1 && s_rdata[32];

	// datapath stages: no reset needed
	always_ff @(posedge clk) begin
		j_s1    <= j_q;
		inr_s1  <= k_in;
		j_s2    <= j_s1;
		use_s2  <= use_s1;
		prod_s2 <= $signed(s_rdata[31:0]) * $signed(w_rdata);
		w_s2    <= $signed(w_rdata);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			out_word  <= '0;
			iss_q     <= 1'b0;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			center_q  <= '0;
			j_q       <= '0;
			acc_q     <= '0;
			wsum_q    <= '0;
			cnt_q     <= '0;
			before_q  <= 1'b0;
			after_q   <= 1'b0;
			miss_q    <= 1'b0;
			num_q     <= '0;
			den_q     <= '0;
			rem_q     <= '0;
			div_cnt_q <= '0;
			neg_q     <= 1'b0;
			res_q     <= '0;
		end else begin
			if (res_load) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			vld_s1 <= (state_q == S_WALK) && iss_q;
			vld_s2 <= vld_s1;

			unique case (state_q)
				S_IDLE: begin
					if (accept && in_word.operation == OP_QUERY) begin
						if (bad_cfg) begin
							res_q   <= '{window_value: '0, status: ST_BAD_CFG};
							state_q <= S_RESULT;
						end else begin
							center_q <= in_word.index;
							j_q      <= '0;
							iss_q    <= 1'b1;
							acc_q    <= '0;
							wsum_q   <= '0;
							cnt_q    <= '0;
							before_q <= 1'b0;
							after_q  <= 1'b0;
							miss_q   <= 1'b0;
							state_q  <= S_WALK;
						end
					end
				end
				S_WALK: begin
					if (iss_q) begin
						if (j_q == nw_m1) iss_q <= 1'b0;
						else j_q <= j_q + 5'd1;
					end
					if (vld_s1 && !use_s1) miss_q <= 1'b1;
					if (vld_s2 && use_s2) begin
						acc_q  <= acc_q + {{4{prod_s2[47]}}, prod_s2};
						wsum_q <= wsum_q + {{5{w_s2[15]}}, w_s2};
						cnt_q  <= cnt_q + 5'd1;
						if (j_s2 <= {1'b0, hw_q}) before_q <= 1'b1;
						if (j_s2 >= {1'b0, hw_q}) after_q  <= 1'b1;
					end
					if (!iss_q && !vld_s1 && !vld_s2) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (!miss_q) begin
						res_q   <= '{window_value: sat32(acc_q[51], 54'(full_mag)),
							status: ST_OK};
						state_q <= S_RESULT;
					end else if (cnt_q < mp_q) begin
						res_q   <= '{window_value: '0, status: ST_FEW};
						state_q <= S_RESULT;
					end else if (bal_q && !(before_q && after_q)) begin
						res_q   <= '{window_value: '0, status: ST_UNBALANCED};
						state_q <= S_RESULT;
					end else if (wsum_q == '0) begin
						res_q   <= '{window_value: '0, status: ST_ZERO_WSUM};
						state_q <= S_RESULT;
					end else begin
						// q = (2|acc| + |wsum|) / (2|wsum|)
						num_q     <= {1'b0, na, 1'b0} + 54'(nd);
						den_q     <= {nd, 1'b0};
						rem_q     <= '0;
						div_cnt_q <= 6'd53;
						neg_q     <= acc_q[51] ^ wsum_q[20];
						state_q   <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= ge ? 22'(rem_sh - {1'b0, den_q}) : rem_sh[21:0];
					num_q <= {num_q[52:0], ge};
					if (div_cnt_q == '0) state_q <= S_RESULT;
					else div_cnt_q <= div_cnt_q - 6'd1;
				end
				S_RESULT: begin
					if (miss_q && res_q.status == ST_OK) begin
						res_q.window_value <= sat32(neg_q, num_q);
						miss_q <= 1'b0;
					end else if (res_load) begin
						out_word  <= res_q;
						miss_q    <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			// clear stale status so a divide result is recognized in S_RESULT
			if (state_q == S_DECIDE && miss_q && !(cnt_q < mp_q) &&
				!(bal_q && !(before_q && after_q)) && wsum_q != '0) begin
				res_q.status <= ST_OK;
			end
		end
	end

endmodule
